// File: design/assert_macros.svh
// Assertion macros used by the checker file gkg_checker.sv.
// Depends on nothing; clock and reset are taken from the scope of the use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge outside reset.
`define GKG_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("gkg assertion failed");

// Checked at every edge, reset included.
`define GKG_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("gkg assertion failed");

`endif

// File: design/gkg_pkg.sv
// Shared types and constants of the gaussian kernel generator.
// Used by the top level and its term and exponent pipelines.
package gkg_pkg;

   localparam int DIM_W  = 12;  // effective width/height
   localparam int DIFF_W = 11;  // |pos - half|
   localparam int SIG_W  = 17;  // effective Q9.8 sigma
   localparam int DSQ_W  = 2 * DIFF_W;
   localparam int SSQ_W  = 2 * SIG_W;
   localparam int QUO_W  = 21;  // quotient bits, enough to exceed the cap
   localparam int ARG_W  = 21;  // Q5.16 exponent, capped at 24.0
   localparam logic [ARG_W-1:0] ARG_CAP = ARG_W'(24 << 16);

   typedef enum logic [2:0] {
      CSR_SIGMA_X      = 3'd0,
      CSR_SIGMA_Y      = 3'd1,
      CSR_SIZE_MODE    = 3'd2,
      CSR_IMAGE_WIDTH  = 3'd3,
      CSR_IMAGE_HEIGHT = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_FIXED           = 2'd0,
      MODE_SIZE_FROM_SIGMA = 2'd1,
      MODE_SIGMA_FROM_SIZE = 2'd2
   } size_mode_type;

endpackage

// File: design/gaussian_kernel_generator.sv
// Gaussian kernel generator: one weight exp(-(dx^2/2sx^2 + dy^2/2sy^2)) in
// unsigned Q0.VALUE_BITS for each (col, row) transaction, in order. It takes
// one transaction per clock while the result is not stalled; its pipeline is
// mostly the 21-stage restoring divider that forms the exponent terms and the
// eight squaring stages of the exponential. A stalled result holds the whole
// pipeline. The user must see that configuration registers are written
// through the csr port while no transaction is in flight; it is not enforced.
module gaussian_kernel_generator #(
   parameter int MAX_DIM    = 1024,
   parameter int VALUE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [9:0]            req_col,
   input  logic [9:0]            req_row,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VALUE_BITS-1:0] rsp_value,
   input  logic                  csr_write,
   input  logic [2:0]            csr_index,
   input  logic [15:0]           csr_data
);

   logic [15:0] sigma_x_ff, sigma_y_ff;
   logic [1:0]  size_mode_ff;
   logic [10:0] image_width_ff, image_height_ff;

   logic                        enable;
   logic [gkg_pkg::DIFF_W-1:0]  diff_ff [2];
   logic [gkg_pkg::DIFF_W-1:0]  diff_in [2];
   logic [gkg_pkg::SIG_W-1:0]   sig_ff  [2];
   logic [gkg_pkg::SIG_W-1:0]   sig_in  [2];
   logic [gkg_pkg::DSQ_W-1:0]   dsq_ff  [2];
   logic [gkg_pkg::SSQ_W-1:0]   ssq_ff  [2];
   logic                        vld_a_ff, vld_b_ff;
   logic                        term_valid;
   logic [gkg_pkg::ARG_W-1:0]   term_arg;

   function automatic logic [gkg_pkg::DIM_W-1:0] dim_from_sigma(input logic [15:0] s);
      logic [16:0] d;
      d = (17'(s) + 17'd63) >> 6;
      if (!d[0]) d = d + 17'd1;
      if (d > 17'(MAX_DIM - 1)) d = 17'(MAX_DIM - 1);
      return gkg_pkg::DIM_W'(d);
   endfunction

   assign enable    = !rsp_valid || !rsp_stall;
   assign req_stall = !enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_x_ff      <= 16'd410;
         sigma_y_ff      <= 16'd410;
         size_mode_ff    <= gkg_pkg::MODE_FIXED;
         image_width_ff  <= 11'd16;
         image_height_ff <= 11'd16;
      end else if (csr_write) begin
         case (gkg_pkg::csr_index_type'(csr_index))
            gkg_pkg::CSR_SIGMA_X:      sigma_x_ff      <= csr_data;
            gkg_pkg::CSR_SIGMA_Y:      sigma_y_ff      <= csr_data;
            gkg_pkg::CSR_SIZE_MODE:    size_mode_ff    <= csr_data[1:0];
            gkg_pkg::CSR_IMAGE_WIDTH:  image_width_ff  <= csr_data[10:0];
            gkg_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_data[10:0];
            default: ;
         endcase
      end
   end

   // Effective size, centre offset and sigma for each axis.
   always_comb begin
      logic [gkg_pkg::DIM_W-1:0]  dim  [2];
      logic [gkg_pkg::SIG_W-1:0]  sig  [2];
      logic [gkg_pkg::DIFF_W-1:0] half;
      logic [gkg_pkg::DIFF_W-1:0] pos  [2];
      dim[0] = gkg_pkg::DIM_W'(image_width_ff);
      dim[1] = gkg_pkg::DIM_W'(image_height_ff);
      sig[0] = gkg_pkg::SIG_W'(sigma_x_ff);
      sig[1] = gkg_pkg::SIG_W'(sigma_y_ff);
      case (gkg_pkg::size_mode_type'(size_mode_ff))
         gkg_pkg::MODE_SIZE_FROM_SIGMA: begin
            dim[0] = dim_from_sigma(sigma_x_ff);
            dim[1] = dim_from_sigma(sigma_y_ff);
         end
         gkg_pkg::MODE_SIGMA_FROM_SIZE: begin
            sig[0] = {image_width_ff, 6'd0};
            sig[1] = {image_height_ff, 6'd0};
         end
         default: ;
      endcase
      pos[0] = gkg_pkg::DIFF_W'(req_col);
      pos[1] = gkg_pkg::DIFF_W'(req_row);
      for (int l = 0; l < 2; l++) begin
         half = dim[l][gkg_pkg::DIM_W-1:1];
         diff_in[l] = (pos[l] >= half) ? pos[l] - half : half - pos[l];
         sig_in[l]  = (sig[l] == '0) ? gkg_pkg::SIG_W'(1) : sig[l];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int l = 0; l < 2; l++) begin
            diff_ff[l] <= diff_in[l];
            sig_ff[l]  <= sig_in[l];
            dsq_ff[l]  <= gkg_pkg::DSQ_W'(diff_ff[l]) * gkg_pkg::DSQ_W'(diff_ff[l]);
            ssq_ff[l]  <= gkg_pkg::SSQ_W'(sig_ff[l]) * gkg_pkg::SSQ_W'(sig_ff[l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else if (enable) begin
         vld_a_ff <= req_valid;
         vld_b_ff <= vld_a_ff;
      end
   end

   gkg_term u_term (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (vld_b_ff),
      .in_dsq   (dsq_ff),
      .in_ssq   (ssq_ff),
      .out_valid(term_valid),
      .out_arg  (term_arg)
   );

   gkg_exp #(
      .VALUE_BITS(VALUE_BITS)
   ) u_exp (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (term_valid),
      .in_arg   (term_arg),
      .out_valid(rsp_valid),
      .out_value(rsp_value)
   );

endmodule

// File: design/gkg_term.sv
// Exponent terms dx^2/(2 sx^2) + dy^2/(2 sy^2) in Q5.16, capped at 24.0.
// Restoring divider, one quotient bit per stage, two lanes; uses gkg_pkg.
module gkg_term (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         in_valid,
   input  logic [gkg_pkg::DSQ_W-1:0]    in_dsq [2],
   input  logic [gkg_pkg::SSQ_W-1:0]    in_ssq [2],
   output logic                         out_valid,
   output logic [gkg_pkg::ARG_W-1:0]    out_arg
);

   localparam int STAGES = gkg_pkg::QUO_W;
   localparam int REM_W  = gkg_pkg::SSQ_W + gkg_pkg::QUO_W;

   logic [REM_W-1:0]           rem_ff [2][STAGES+1];
   logic [REM_W-1:0]           rem_in [2][STAGES+1];
   logic [gkg_pkg::SSQ_W-1:0]  den_ff [2][STAGES+1];
   logic [gkg_pkg::QUO_W-1:0]  quo_ff [2][STAGES+1];
   logic [gkg_pkg::QUO_W-1:0]  quo_in [2][STAGES+1];
   logic                       ovf_ff [2][STAGES+1];
   logic                       ovf_in [2];
   logic                       vld_ff [STAGES+2];
   logic [gkg_pkg::ARG_W-1:0]  arg_ff;
   logic [gkg_pkg::ARG_W-1:0]  arg_in;

   always_comb begin
      logic [REM_W-1:0]          num;
      logic [REM_W-1:0]          trial;
      logic [gkg_pkg::ARG_W-1:0] term [2];
      logic [gkg_pkg::ARG_W:0]   total;
      for (int l = 0; l < 2; l++) begin
         num = REM_W'({in_dsq[l], 31'd0});
         rem_in[l][0] = num;
         quo_in[l][0] = '0;
         ovf_in[l]    = num >= {in_ssq[l], gkg_pkg::QUO_W'(0)};
         for (int s = 0; s < STAGES; s++) begin
            trial = {den_ff[l][s], gkg_pkg::QUO_W'(0)} >> (s + 1);
            if (rem_ff[l][s] >= trial) begin
               rem_in[l][s+1] = rem_ff[l][s] - trial;
               quo_in[l][s+1] = {quo_ff[l][s][gkg_pkg::QUO_W-2:0], 1'b1};
            end else begin
               rem_in[l][s+1] = rem_ff[l][s];
               quo_in[l][s+1] = {quo_ff[l][s][gkg_pkg::QUO_W-2:0], 1'b0};
            end
         end
         if (ovf_ff[l][STAGES] || (quo_ff[l][STAGES] > gkg_pkg::QUO_W'(gkg_pkg::ARG_CAP)))
            term[l] = gkg_pkg::ARG_CAP;
         else
            term[l] = gkg_pkg::ARG_W'(quo_ff[l][STAGES]);
      end
      total = {1'b0, term[0]} + {1'b0, term[1]};
      arg_in = (total > {1'b0, gkg_pkg::ARG_CAP}) ? gkg_pkg::ARG_CAP
                                                   : total[gkg_pkg::ARG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int l = 0; l < 2; l++) begin
            rem_ff[l][0] <= rem_in[l][0];
            quo_ff[l][0] <= quo_in[l][0];
            den_ff[l][0] <= in_ssq[l];
            ovf_ff[l][0] <= ovf_in[l];
            for (int s = 0; s < STAGES; s++) begin
               rem_ff[l][s+1] <= rem_in[l][s+1];
               quo_ff[l][s+1] <= quo_in[l][s+1];
               den_ff[l][s+1] <= den_ff[l][s];
               ovf_ff[l][s+1] <= ovf_ff[l][s];
            end
         end
         arg_ff <= arg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES + 2; s++) vld_ff[s] <= 1'b0;
      end else if (enable) begin
         vld_ff[0] <= in_valid;
         for (int s = 0; s < STAGES + 1; s++) vld_ff[s+1] <= vld_ff[s];
      end
   end

   assign out_valid = vld_ff[STAGES+1];
   assign out_arg   = arg_ff;

endmodule

// File: design/gkg_exp.sv
// exp(-a) for a Q5.16 exponent: Taylor series of exp(-a/256), then eight
// rounded squarings, then rounding to the output fraction. Uses gkg_pkg.
module gkg_exp #(
   parameter int VALUE_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       enable,
   input  logic                       in_valid,
   input  logic [gkg_pkg::ARG_W-1:0]  in_arg,
   output logic                       out_valid,
   output logic [VALUE_BITS-1:0]      out_value
);

   // Exact division by constants: multiply by ceil(2^K/c), shift by K.
   localparam int K3 = 27;
   localparam int K4 = 25;
   localparam int K5 = 23;
   localparam int K6 = 23;
   localparam logic [31:0] M3 = 32'(((64'd1 << K3) + 64'd5) / 64'd6);
   localparam logic [31:0] M4 = 32'(((64'd1 << K4) + 64'd23) / 64'd24);
   localparam logic [31:0] M5 = 32'(((64'd1 << K5) + 64'd119) / 64'd120);
   localparam logic [31:0] M6 = 32'(((64'd1 << K6) + 64'd719) / 64'd720);
   localparam int SQ_N   = 8;
   localparam int LAST   = 7 + SQ_N;
   localparam int OUT_W  = 33 + VALUE_BITS + 1;

   logic [31:0] t_ff [0:6];
   logic [31:0] t2_ff, t3_ff, t4_ff, t5_ff, t6_ff;
   logic [31:0] t2_in, t3_in, t4_in, t5_in, t6_in;
   logic [31:0] h2_ff [2:6];
   logic [31:0] q3_ff [3:6];
   logic [31:0] q4_ff [4:6];
   logic [31:0] q5_ff [5:6];
   logic [31:0] q6_ff;
   logic [31:0] q3_in, q4_in, q5_in, q6_in;
   logic [31:0] sq_ff [0:SQ_N];
   logic [31:0] sq_in [0:SQ_N];
   logic        zero_ff [0:LAST];
   logic        cap_ff  [0:LAST];
   logic        vld_ff  [0:LAST+1];
   logic [VALUE_BITS-1:0] value_ff;
   logic [VALUE_BITS-1:0] value_in;

   always_comb begin
      logic [63:0]          prod;
      logic [33:0]          sum;
      logic [32:0]          e;
      logic [OUT_W-1:0]     rnd;
      logic [VALUE_BITS+1:0] v;
      prod  = 64'(t_ff[0]) * 64'(t_ff[0]);
      t2_in = prod[63:32];
      prod  = 64'(t2_ff) * 64'(t_ff[1]);
      t3_in = prod[63:32];
      prod  = 64'(t3_ff) * 64'(t_ff[2]);
      t4_in = prod[63:32];
      prod  = 64'(t4_ff) * 64'(t_ff[3]);
      t5_in = prod[63:32];
      prod  = 64'(t5_ff) * 64'(t_ff[4]);
      t6_in = prod[63:32];
      prod  = 64'(t3_ff[23:0]) * 64'(M3);
      q3_in = 32'(prod >> K3);
      prod  = 64'(t4_ff[19:0]) * 64'(M4);
      q4_in = 32'(prod >> K4);
      prod  = 64'(t5_ff[15:0]) * 64'(M5);
      q5_in = 32'(prod >> K5);
      prod  = 64'(t6_ff[12:0]) * 64'(M6);
      q6_in = 32'(prod >> K6);

      sum = (34'd1 << 32) - 34'(t_ff[6]) + 34'(h2_ff[6]) - 34'(q3_ff[6])
            + 34'(q4_ff[6]) - 34'(q5_ff[6]) + 34'(q6_ff);
      sq_in[0] = (sum >= (34'd1 << 32)) ? 32'hFFFF_FFFF : sum[31:0];
      for (int i = 0; i < SQ_N; i++) begin
         prod = 64'(sq_ff[i]) * 64'(sq_ff[i]) + 64'h8000_0000;
         sq_in[i+1] = prod[63:32];
      end

      // Centre gives exactly one, a capped exponent gives zero.
      if (zero_ff[LAST])     e = 33'h1_0000_0000;
      else if (cap_ff[LAST]) e = '0;
      else                   e = {1'b0, sq_ff[SQ_N]};
      rnd = (OUT_W'(e) << VALUE_BITS) + (OUT_W'(1) << 31);
      v   = rnd[OUT_W-1:32];
      value_in = (v > (VALUE_BITS+2)'({VALUE_BITS{1'b1}})) ? {VALUE_BITS{1'b1}}
                                                          : v[VALUE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         t_ff[0]    <= {3'd0, in_arg, 8'd0};
         zero_ff[0] <= in_arg == '0;
         cap_ff[0]  <= in_arg >= gkg_pkg::ARG_CAP;
         for (int i = 0; i < 6; i++) t_ff[i+1] <= t_ff[i];
         for (int i = 0; i < LAST; i++) begin
            zero_ff[i+1] <= zero_ff[i];
            cap_ff[i+1]  <= cap_ff[i];
         end
         t2_ff    <= t2_in;
         t3_ff    <= t3_in;
         h2_ff[2] <= t2_ff >> 1;
         t4_ff    <= t4_in;
         q3_ff[3] <= q3_in;
         t5_ff    <= t5_in;
         q4_ff[4] <= q4_in;
         t6_ff    <= t6_in;
         q5_ff[5] <= q5_in;
         q6_ff    <= q6_in;
         for (int i = 2; i < 6; i++) h2_ff[i+1] <= h2_ff[i];
         for (int i = 3; i < 6; i++) q3_ff[i+1] <= q3_ff[i];
         for (int i = 4; i < 6; i++) q4_ff[i+1] <= q4_ff[i];
         q5_ff[6] <= q5_ff[5];
         for (int i = 0; i <= SQ_N; i++) sq_ff[i] <= sq_in[i];
         value_ff <= value_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAST + 1; i++) vld_ff[i] <= 1'b0;
      end else if (enable) begin
         vld_ff[0] <= in_valid;
         for (int i = 0; i <= LAST; i++) vld_ff[i+1] <= vld_ff[i];
      end
   end

   assign out_valid = vld_ff[LAST+1];
   assign out_value = value_ff;

endmodule

// File: design/gkg_checker.sv
// Port-level checks of the gaussian kernel generator, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module gkg_checker #(
   parameter int VALUE_BITS = 16
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [VALUE_BITS-1:0] rsp_value
);

   // Reset empties the pipeline.
   `GKG_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid)
   // Input backs up only behind a stalled result.
   `GKG_ASSERT(a_stall_cause, req_stall |-> (rsp_valid && rsp_stall))
   // A stalled result blocks new transactions.
   `GKG_ASSERT(a_stall_blocks, (rsp_valid && rsp_stall) |-> req_stall)
   // Held result keeps its value.
   `GKG_ASSERT(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_value)))

endmodule

bind gaussian_kernel_generator gkg_checker #(
   .VALUE_BITS(VALUE_BITS)
) u_gkg_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_value(rsp_value)
);
